### rtl/lc3_pkg.sv
// ----------------------------------------------------------------------------
// lc3_pkg
// Shared types and constants for the LC-3 instruction executor: item
// operations, instruction opcodes, condition code encodings.
// ----------------------------------------------------------------------------
package lc3_pkg;

  localparam int ADDR_BITS_DEF = 16;
  localparam int WORD_BITS     = 16;
  localparam int REG_COUNT     = 8;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_SETPC = 2'd1,
    OP_EXEC  = 2'd2,
    OP_READ  = 2'd3
  } item_op_t;

  typedef enum logic [3:0] {
    OPC_BR   = 4'h0,
    OPC_ADD  = 4'h1,
    OPC_LD   = 4'h2,
    OPC_ST   = 4'h3,
    OPC_JSR  = 4'h4,
    OPC_AND  = 4'h5,
    OPC_LDR  = 4'h6,
    OPC_STR  = 4'h7,
    OPC_RTI  = 4'h8,
    OPC_NOT  = 4'h9,
    OPC_LDI  = 4'hA,
    OPC_STI  = 4'hB,
    OPC_JMP  = 4'hC,
    OPC_RES  = 4'hD,
    OPC_LEA  = 4'hE,
    OPC_TRAP = 4'hF
  } opc_t;

  localparam logic [2:0] NZP_N = 3'b100;
  localparam logic [2:0] NZP_Z = 3'b010;
  localparam logic [2:0] NZP_P = 3'b001;

  localparam logic [7:0] VEC_HALT = 8'h25;
  localparam logic [2:0] REG_LINK = 3'd7;
  localparam logic [2:0] REG_ARG  = 3'd0;

  function automatic logic [2:0] nzp_of(input logic [WORD_BITS-1:0] v);
    logic [2:0] f;
    if (v == '0) begin
      f = NZP_Z;
    end else if (v[WORD_BITS-1]) begin
      f = NZP_N;
    end else begin
      f = NZP_P;
    end
    return f;
  endfunction

endpackage

### rtl/lc3_instruction_executor.sv
// ----------------------------------------------------------------------------
// lc3_instruction_executor
// 16-bit LC-3 core: word memory, eight registers, pc and nzp flags.
//
// Input beats (in_valid/in_ready) carry an operation: load a memory word,
// set the pc, read a memory word, or fetch and execute one instruction at
// the pc. Every input beat yields exactly one output beat (out_valid/
// out_ready) with the word read or fetched, the pc and nzp after the beat,
// and trap information.
// One item is worked on at a time. A load or set pc goes straight to S_DONE,
// a read passes S_READ, and execute passes S_DEC, S_RA and S_EX, then S_MEM
// for LD and LDR, S_IND for STI, and S_IND and S_MEM for LDI. in_ready
// returns at the same edge that raises out_valid. The sequence of states
// is set by the main memory port (one read and one write port, registered
// read data) and the register file read port (one register per cycle).
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver still stalls when the next result is ready, the
// block holds that result and stops accepting until the output frees up.
// Reset clears registers to zero, pc to zero, nzp to Z and drops out_valid.
// Memory contents are undefined until written.
// ----------------------------------------------------------------------------
module lc3_instruction_executor #(
  parameter int ADDR_BITS = lc3_pkg::ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_address,
  input  logic [15:0] in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_read_data,
  output logic [15:0] out_next_pc,
  output logic [2:0]  out_condition_codes,
  output logic        out_trap_taken,
  output logic [7:0]  out_trap_vector,
  output logic [15:0] out_trap_argument,
  output logic        out_halted
);

  import lc3_pkg::*;

  localparam int MEM_DEPTH = 1 << ADDR_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DEC,
    S_RA,
    S_EX,
    S_IND,
    S_MEM,
    S_DONE
  } state_t;

  state_t state_r;

  logic [15:0] pc_r;
  logic [2:0]  nzp_r;
  logic [15:0] ins_r;
  logic [15:0] a_r;
  logic [15:0] b_r;
  logic [REG_COUNT-1:0] rf_valid_r;
  logic [2:0]  rf_rsel_r;

  logic [15:0] res_rd_r;
  logic        trap_r;
  logic [7:0]  vec_r;
  logic [15:0] targ_r;
  logic        halt_r;

  logic        out_valid_r;
  logic [15:0] out_read_data_r;
  logic [15:0] out_next_pc_r;
  logic [2:0]  out_cc_r;
  logic        out_trap_r;
  logic [7:0]  out_vec_r;
  logic [15:0] out_targ_r;
  logic        out_halt_r;

  // memory ports
  logic        mem_we;
  logic [15:0] mem_waddr;
  logic [15:0] mem_wdata;
  logic [15:0] mem_raddr;
  logic [15:0] mem_rdata;

  logic        rf_we;
  logic [2:0]  rf_waddr;
  logic [15:0] rf_wdata;
  logic [2:0]  rf_raddr;
  logic [15:0] rf_rdata;
  logic [15:0] rf_q;
  logic        rf_sets_cc;

  opc_t        opc;
  logic [15:0] off9, off6, off11, imm5;
  logic [15:0] pc_off9, base_off6, src2, alu;
  logic        in_fire;
  logic        out_free;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign opc       = opc_t'(ins_r[15:12]);
  assign off9      = {{7{ins_r[8]}}, ins_r[8:0]};
  assign off6      = {{10{ins_r[5]}}, ins_r[5:0]};
  assign off11     = {{5{ins_r[10]}}, ins_r[10:0]};
  assign imm5      = {{11{ins_r[4]}}, ins_r[4:0]};
  assign pc_off9   = pc_r + off9;
  assign base_off6 = a_r + off6;
  assign rf_q      = rf_valid_r[rf_rsel_r] ? rf_rdata : '0;
  assign src2      = ins_r[5] ? imm5 : rf_q;

  always_comb begin
    unique case (opc)
      OPC_ADD: alu = a_r + src2;
      OPC_AND: alu = a_r & src2;
      OPC_NOT: alu = ~a_r;
      OPC_LEA: alu = pc_off9;
      OPC_JSR: alu = pc_r;
      default: alu = a_r;
    endcase
  end

  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = pc_off9;
    mem_wdata  = rf_q;
    mem_raddr  = pc_off9;
    rf_we      = 1'b0;
    rf_waddr   = ins_r[11:9];
    rf_wdata   = alu;
    rf_raddr   = ins_r[11:9];
    rf_sets_cc = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        mem_waddr = in_address;
        mem_wdata = in_data;
        mem_raddr = (item_op_t'(in_operation) == OP_EXEC) ? pc_r : in_address;
        mem_we    = in_fire && (item_op_t'(in_operation) == OP_LOAD);
      end
      S_DEC: begin
        rf_raddr = mem_rdata[8:6];
      end
      S_RA: begin
        case (opc) inside
          OPC_TRAP:         rf_raddr = REG_ARG;
          OPC_ADD, OPC_AND: rf_raddr = ins_r[2:0];
          default:          rf_raddr = ins_r[11:9];
        endcase
      end
      S_EX: begin
        case (opc) inside
          OPC_ADD, OPC_AND, OPC_NOT: begin
            rf_we      = 1'b1;
            rf_sets_cc = 1'b1;
          end
          OPC_LEA: rf_we = 1'b1;
          OPC_JSR: begin
            rf_we    = 1'b1;
            rf_waddr = REG_LINK;
          end
          OPC_LDR: mem_raddr = base_off6;
          OPC_ST:  mem_we = 1'b1;
          OPC_STR: begin
            mem_we    = 1'b1;
            mem_waddr = base_off6;
          end
          default: ;
        endcase
      end
      S_IND: begin
        mem_raddr = mem_rdata;
        mem_waddr = mem_rdata;
        mem_wdata = b_r;
        mem_we    = (opc == OPC_STI);
      end
      S_MEM: begin
        rf_we      = 1'b1;
        rf_wdata   = mem_rdata;
        rf_sets_cc = 1'b1;
      end
      default: ;
    endcase
  end

  lc3_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MEM_DEPTH)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr[ADDR_BITS-1:0]),
    .wdata(mem_wdata),
    .raddr(mem_raddr[ADDR_BITS-1:0]),
    .rdata(mem_rdata)
  );

  lc3_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(REG_COUNT)
  ) u_rf (
    .clk  (clk),
    .we   (rf_we),
    .waddr(rf_waddr),
    .wdata(rf_wdata),
    .raddr(rf_raddr),
    .rdata(rf_rdata)
  );

  always_ff @(posedge clk) begin
    rf_rsel_r <= rf_raddr;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      nzp_r       <= NZP_Z;
      rf_valid_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (rf_we) begin
        rf_valid_r[rf_waddr] <= 1'b1;
      end
      if (rf_we && rf_sets_cc) begin
        nzp_r <= nzp_of(rf_wdata);
      end
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            res_rd_r <= '0;
            trap_r   <= 1'b0;
            vec_r    <= '0;
            targ_r   <= '0;
            halt_r   <= 1'b0;
            unique case (item_op_t'(in_operation))
              OP_LOAD:  state_r <= S_DONE;
              OP_SETPC: begin
                pc_r    <= in_address;
                state_r <= S_DONE;
              end
              OP_READ:  state_r <= S_READ;
              OP_EXEC:  state_r <= S_DEC;
              default:  state_r <= S_DONE;
            endcase
          end
        end
        S_READ: begin
          res_rd_r <= mem_rdata;
          state_r  <= S_DONE;
        end
        S_DEC: begin
          ins_r    <= mem_rdata;
          res_rd_r <= mem_rdata;
          pc_r     <= pc_r + 16'd1;
          state_r  <= S_RA;
        end
        S_RA: begin
          a_r     <= rf_q;
          state_r <= S_EX;
        end
        S_EX: begin
          b_r <= rf_q;
          case (opc) inside
            OPC_LD, OPC_LDR:  state_r <= S_MEM;
            OPC_LDI, OPC_STI: state_r <= S_IND;
            default:          state_r <= S_DONE;
          endcase
          case (opc) inside
            OPC_BR: begin
              if ((ins_r[11:9] & nzp_r) != 3'b000) begin
                pc_r <= pc_off9;
              end
            end
            OPC_JSR:          pc_r <= ins_r[11] ? (pc_r + off11) : a_r;
            OPC_JMP:          pc_r <= a_r;
            OPC_TRAP: begin
              trap_r <= 1'b1;
              vec_r  <= ins_r[7:0];
              targ_r <= rf_q;
              halt_r <= (ins_r[7:0] == VEC_HALT);
            end
            default: ;
          endcase
        end
        S_IND: begin
          state_r <= (opc == OPC_LDI) ? S_MEM : S_DONE;
        end
        S_MEM: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r     <= 1'b1;
            out_read_data_r <= res_rd_r;
            out_next_pc_r   <= pc_r;
            out_cc_r        <= nzp_r;
            out_trap_r      <= trap_r;
            out_vec_r       <= vec_r;
            out_targ_r      <= targ_r;
            out_halt_r      <= halt_r;
            state_r         <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_read_data       = out_read_data_r;
  assign out_next_pc         = out_next_pc_r;
  assign out_condition_codes = out_cc_r;
  assign out_trap_taken      = out_trap_r;
  assign out_trap_vector     = out_vec_r;
  assign out_trap_argument   = out_targ_r;
  assign out_halted          = out_halt_r;

  // at most one write port busy per cycle
  a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && rf_we))
    else $error("memory and register file written in the same cycle");

  a_nzp_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(nzp_r))
    else $error("condition codes not one-hot");

  a_pc_incr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEC) |=> (pc_r == $past(pc_r) + 16'd1))
    else $error("pc not incremented at decode");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("finished result not presented");

endmodule

### rtl/lc3_ram.sv
// ----------------------------------------------------------------------------
// lc3_ram
// Generic synchronous RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module lc3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
